FILE: sv/qks_pkg.sv
// Shared types and constants for the quadrature knob setpoint block.
`timescale 1ns / 1ps

package qks_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned STEP_W         = 10;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [STEP_W-1:0]  STEP_SIZE_RST    = 10'd60;
  localparam logic [FIELD_W-1:0] MAX_VALUE_RST    = 16'd480;
  localparam logic [FIELD_W-1:0] IDLE_TIMEOUT_RST = 16'd2000;

  // Quadrature phases, A in bit 1 and B in bit 0
  localparam logic [1:0] PHASE_LOW  = 2'b00;
  localparam logic [1:0] PHASE_HIGH = 2'b11;
  localparam logic [1:0] PHASE_A    = 2'b10;
  localparam logic [1:0] PHASE_B    = 2'b01;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIN    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REMOTE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_MAX_VALUE    = 2'd1,
    REG_IDLE_TIMEOUT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic               pin_a;
    logic               pin_b;
    logic               key_level;
    logic [FIELD_W-1:0] remote_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] shown_value;
    logic               moving;
    logic               commit;
    logic               mode_flag;
    logic               mode_changed;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_size;
    logic [FIELD_W-1:0] max_value;
    logic [FIELD_W-1:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic detent;
    dir_e dir;
    logic mode_flag;
    logic mode_changed;
  } knob_evt_t;

endpackage

FILE: sv/qks_quad_decoder.sv
// Quadrature phase decoder with detent detection and key edge mode toggle.
`timescale 1ns / 1ps

module qks_quad_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  qks_pkg::in_item_t    item_i,
  output qks_pkg::knob_evt_t   evt_o
);
  import qks_pkg::*;

  logic [1:0] last_q, last_d;
  logic       primed_q, primed_d;
  dir_e       dir_q, dir_d;
  logic       key_prev_q, key_prev_d;
  logic       mode_q, mode_d;
  logic [1:0] phase;
  logic       reached;
  logic       toggled;

  assign phase = {item_i.pin_a, item_i.pin_b};

  always_comb begin
    last_d     = last_q;
    primed_d   = primed_q;
    dir_d      = dir_q;
    key_prev_d = key_prev_q;
    mode_d     = mode_q;
    reached    = 1'b0;
    toggled    = 1'b0;
    if (item_i.command == CMD_PIN) begin
      toggled    = !item_i.key_level && key_prev_q;
      mode_d     = mode_q ^ toggled;
      key_prev_d = item_i.key_level;
      primed_d   = 1'b1;
      if (phase != last_q) begin
        case (phase) inside
          PHASE_LOW, PHASE_HIGH: begin
            last_d  = phase;
            reached = 1'b1;
          end
          PHASE_A: begin
            if (last_q == PHASE_LOW) dir_d = DIR_INC;
            else if (last_q == PHASE_HIGH) dir_d = DIR_DEC;
          end
          default: begin
            if (last_q == PHASE_LOW) dir_d = DIR_DEC;
            else if (last_q == PHASE_HIGH) dir_d = DIR_INC;
          end
        endcase
      end
    end
  end

  // The first sample only records the phase
  assign evt_o.detent       = reached && primed_q;
  assign evt_o.dir          = dir_d;
  assign evt_o.mode_flag    = mode_d;
  assign evt_o.mode_changed = toggled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= PHASE_LOW;
      primed_q   <= 1'b0;
      dir_q      <= DIR_NONE;
      key_prev_q <= 1'b0;
      mode_q     <= 1'b0;
    end else if (fire_i) begin
      last_q     <= last_d;
      primed_q   <= primed_d;
      dir_q      <= dir_d;
      key_prev_q <= key_prev_d;
      mode_q     <= mode_d;
    end
  end

endmodule

FILE: sv/qks_setpoint.sv
// Setpoint stepping, idle timer, commit and remote tracking.
`timescale 1ns / 1ps

module qks_setpoint #(
  parameter int unsigned VALUE_BITS = qks_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  qks_pkg::in_item_t    item_i,
  input  qks_pkg::knob_evt_t   evt_i,
  input  qks_pkg::cfg_t        cfg_i,
  output qks_pkg::out_item_t   result_o
);
  import qks_pkg::*;

  localparam int unsigned CALC_W = ((VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W) + 1;

  logic [VALUE_BITS-1:0] sp_q, sp_d;
  logic [VALUE_BITS-1:0] rc_q, rc_d;
  logic                  moving_q, moving_d;
  logic [FIELD_W-1:0]    idle_q, idle_d;
  logic [CALC_W-1:0]     sp_w, step_w, max_w, sum_w;
  logic                  commit;
  logic                  known_cmd;

  assign sp_w   = CALC_W'(sp_q);
  assign step_w = CALC_W'(cfg_i.step_size);
  assign max_w  = CALC_W'(cfg_i.max_value);
  assign sum_w  = sp_w + step_w;

  always_comb begin
    sp_d      = sp_q;
    rc_d      = rc_q;
    moving_d  = moving_q;
    idle_d    = idle_q;
    commit    = 1'b0;
    known_cmd = 1'b1;
    case (item_i.command)
      CMD_PIN: begin
        if (evt_i.detent) begin
          idle_d   = '0;
          moving_d = 1'b1;
          if (evt_i.dir == DIR_INC) begin
            sp_d = (sum_w > max_w) ? VALUE_BITS'(max_w) : VALUE_BITS'(sum_w);
          end else if (evt_i.dir == DIR_DEC) begin
            sp_d = (sp_w > step_w) ? VALUE_BITS'(sp_w - step_w) : '0;
          end
        end
      end
      CMD_TICK: begin
        if (idle_q != '1) idle_d = idle_q + FIELD_W'(1);
      end
      CMD_REMOTE: begin
        rc_d = VALUE_BITS'(item_i.remote_value);
      end
      default: begin
        known_cmd = 1'b0;
      end
    endcase
    // Settle: commit after timeout, else follow the remote copy while idle
    if (known_cmd) begin
      if (moving_d) begin
        if (idle_d >= cfg_i.idle_timeout) begin
          if (sp_d != rc_d) begin
            commit = 1'b1;
            rc_d   = sp_d;
          end
          moving_d = 1'b0;
        end
      end else begin
        sp_d = rc_d;
      end
    end
  end

  assign result_o.shown_value  = moving_d ? FIELD_W'(sp_d) : FIELD_W'(rc_d);
  assign result_o.moving       = moving_d;
  assign result_o.commit       = commit;
  assign result_o.mode_flag    = evt_i.mode_flag;
  assign result_o.mode_changed = evt_i.mode_changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      rc_q     <= '0;
      moving_q <= 1'b0;
      idle_q   <= '0;
    end else if (fire_i) begin
      sp_q     <= sp_d;
      rc_q     <= rc_d;
      moving_q <= moving_d;
      idle_q   <= idle_d;
    end
  end

endmodule

FILE: sv/quadrature_knob_setpoint_top.sv
// Throughput: one transaction per cycle while out_stall_i is low; the input
// register and the result register each hold one transaction, and the state
// update is one short pass between the input register and the result register.
// Reset: asynchronous, active low; clears knob state, setpoint and remote copy,
// and loads the configuration registers with their defaults. No clearing pass.
`timescale 1ns / 1ps

module quadrature_knob_setpoint_top #(
  parameter int unsigned VALUE_BITS = qks_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  qks_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output qks_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qks_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qks_pkg::FIELD_W-1:0]       cfg_data_i
);
  import qks_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  cfg_t      cfg_q;
  knob_evt_t evt;
  out_item_t result;
  logic      out_free;
  logic      fire;
  logic      in_accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= STEP_SIZE_RST;
      cfg_q.max_value    <= MAX_VALUE_RST;
      cfg_q.idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_SIZE:    cfg_q.step_size    <= cfg_data_i[STEP_W-1:0];
        REG_MAX_VALUE:    cfg_q.max_value    <= cfg_data_i;
        REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) s1_valid_q <= 1'b1;
      else if (fire) s1_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_item_q <= in_data_i;
    if (fire) out_item_q <= result;
  end

  qks_quad_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .evt_o  (evt)
  );

  qks_setpoint #(
    .VALUE_BITS (VALUE_BITS)
  ) u_setpoint (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .evt_i    (evt),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  a_commit_ends_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.commit |-> !out_item_q.moving)
    else $error("commit reported while still moving");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!s1_valid_q || fire))
    else $error("input register overwritten before it advanced");

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a pending transaction");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && !$past(fire))
    else $error("stalled result register was advanced");

endmodule
